/* sv/lgmw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgmw_pkg
// Shared constants and register codes of the linear gradient mask weight block.
// ----------------------------------------------------------------------------
package lgmw_pkg;

    // configuration port
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X      = 3'd0,
        REG_START_Y      = 3'd1,
        REG_END_X        = 3'd2,
        REG_END_Y        = 3'd3,
        REG_ASPECT_RATIO = 3'd4
    } cfg_reg_t;

    // field widths
    localparam int COORD_W  = 18;
    localparam int PIXEL_W  = 16;
    localparam int ASPECT_W = 16;
    localparam int WEIGHT_W = 16;

    // aspect ratio is unsigned Q4.12
    localparam int ASPECT_FRAC = 12;

    // default weight fraction bits
    localparam int WEIGHT_BITS_DEF = 16;

    // reset values of the registers
    localparam logic [COORD_W-1:0]  START_X_RST = 18'd0;
    localparam logic [COORD_W-1:0]  START_Y_RST = 18'd0;
    localparam logic [COORD_W-1:0]  END_X_RST   = 18'd0;
    localparam logic [COORD_W-1:0]  END_Y_RST   = 18'd65536;
    localparam logic [ASPECT_W-1:0] ASPECT_RST  = 16'd4096;

endpackage

/* sv/linear_gradient_mask_weight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_gradient_mask_weight
// Smoothstep weight of a linear gradient mask, one pixel per clock.
// ----------------------------------------------------------------------------
// usage
//   configuration: cfg_write/cfg_index/cfg_data write start_x, start_y, end_x,
//     end_y and aspect_ratio; write only while no pixel is in flight,
//     unknown indexes are dropped
//   input: a pixel beat (pixel_u, pixel_v) is taken at every clock edge with
//     start high; busy never rises, so the block takes one beat per clock
//   output: done marks weight for exactly one cycle, results leave in the
//     order the pixels came in; the receiver cannot stall, and there is no
//     holding stage since nothing pushes back
//   divider: the 16-stage restoring divider computes one quotient bit per
//     stage; throughput is one beat per cycle
//   pipeline: differences, aspect scaling, products, sums, range check,
//     WEIGHT_BITS divider stages, t squared, smoothstep product, saturation
//   reset: valid bits clear so nothing in flight comes out, and the registers
//     return to start (0,0), end (0,1.0), aspect 1.0
// ----------------------------------------------------------------------------
module linear_gradient_mask_weight #(
    parameter int WEIGHT_BITS = lgmw_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [lgmw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lgmw_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel command
    input  logic                                start,
    output logic                                busy,
    input  logic [lgmw_pkg::PIXEL_W-1:0]        pixel_u,
    input  logic [lgmw_pkg::PIXEL_W-1:0]        pixel_v,
    // weight result
    output logic                                done,
    output logic [lgmw_pkg::WEIGHT_W-1:0]       weight
);

    localparam int W       = WEIGHT_BITS;
    localparam int CW      = lgmw_pkg::COORD_W;
    localparam int DIFF_W  = CW + 1;                  // signed differences
    localparam int MAG_W   = CW;                      // their magnitudes
    localparam int AW      = lgmw_pkg::ASPECT_W;
    localparam int AF      = lgmw_pkg::ASPECT_FRAC;
    localparam int SPROD_W = MAG_W + AW + 1;          // scale product plus rounding
    localparam int SCL_W   = MAG_W + AW - AF;         // scaled x magnitude
    localparam int XX_W    = 2 * SCL_W;               // x products
    localparam int YY_W    = 2 * DIFF_W;              // signed y products
    localparam int LEN_W   = XX_W + 2;                // squared length
    localparam int NUM_W   = LEN_W + 1;               // signed projection
    localparam int WX      = (W > lgmw_pkg::WEIGHT_W) ? W : lgmw_pkg::WEIGHT_W;

    localparam logic [SPROD_W-1:0] SCL_HALF = SPROD_W'(1) << (AF - 1);
    localparam logic [2*W-1:0]     TT_HALF  = (2*W)'(1) << (W - 1);
    localparam logic [2*W+1:0]     P_HALF   = (2*W+2)'(1) << (W - 1);
    localparam logic [W+1:0]       K_THREE  = (W+2)'(3) << W;
    localparam logic [W+1:0]       S_MAX    = {2'b00, {W{1'b1}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [AW-1:0] aspect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= lgmw_pkg::START_X_RST;
            start_y_reg <= lgmw_pkg::START_Y_RST;
            end_x_reg   <= lgmw_pkg::END_X_RST;
            end_y_reg   <= lgmw_pkg::END_Y_RST;
            aspect_reg  <= lgmw_pkg::ASPECT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lgmw_pkg::REG_START_X:      start_x_reg <= cfg_data;
                lgmw_pkg::REG_START_Y:      start_y_reg <= cfg_data;
                lgmw_pkg::REG_END_X:        end_x_reg   <= cfg_data;
                lgmw_pkg::REG_END_Y:        end_y_reg   <= cfg_data;
                lgmw_pkg::REG_ASPECT_RATIO: aspect_reg  <= cfg_data[AW-1:0];
                default: ;                  // unknown index, dropped
            endcase
        end
    end

    // every beat is taken at once
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: offsets from the start point, x split into sign and magnitude
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic                     s1_dx_neg_reg, s1_px_neg_reg;
    logic [MAG_W-1:0]         s1_dx_mag_reg, s1_px_mag_reg;
    logic signed [DIFF_W-1:0] s1_dy_reg, s1_py_reg;

    logic signed [DIFF_W-1:0] dx_raw, px_raw;

    always_comb
    begin
        dx_raw = $signed({end_x_reg[CW-1], end_x_reg}) - $signed({start_x_reg[CW-1], start_x_reg});
        px_raw = $signed({3'b000, pixel_u}) - $signed({start_x_reg[CW-1], start_x_reg});
    end

    always_ff @(posedge clk)
    begin
        s1_dx_neg_reg <= dx_raw[DIFF_W-1];
        s1_px_neg_reg <= px_raw[DIFF_W-1];
        s1_dx_mag_reg <= dx_raw[DIFF_W-1] ? MAG_W'(-dx_raw) : MAG_W'(dx_raw);
        s1_px_mag_reg <= px_raw[DIFF_W-1] ? MAG_W'(-px_raw) : MAG_W'(px_raw);
        s1_dy_reg     <= $signed({end_y_reg[CW-1], end_y_reg})
                         - $signed({start_y_reg[CW-1], start_y_reg});
        s1_py_reg     <= $signed({3'b000, pixel_v}) - $signed({start_y_reg[CW-1], start_y_reg});
    end

    // ------------------------------------------------------------------
    // stage 2: aspect scaling of x magnitudes, rounded half up
    // ------------------------------------------------------------------
    logic                     s2_valid_reg;
    logic                     s2_dx_neg_reg, s2_px_neg_reg;
    logic [SCL_W-1:0]         s2_dx_reg, s2_px_reg;
    logic signed [DIFF_W-1:0] s2_dy_reg, s2_py_reg;

    logic [SPROD_W-1:0] dx_sprod, px_sprod;

    always_comb
    begin
        dx_sprod = SPROD_W'(s1_dx_mag_reg) * SPROD_W'(aspect_reg) + SCL_HALF;
        px_sprod = SPROD_W'(s1_px_mag_reg) * SPROD_W'(aspect_reg) + SCL_HALF;
    end

    always_ff @(posedge clk)
    begin
        s2_dx_neg_reg <= s1_dx_neg_reg;
        s2_px_neg_reg <= s1_px_neg_reg;
        s2_dx_reg     <= dx_sprod[AF+SCL_W-1:AF];
        s2_px_reg     <= px_sprod[AF+SCL_W-1:AF];
        s2_dy_reg     <= s1_dy_reg;
        s2_py_reg     <= s1_py_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: the four products
    // ------------------------------------------------------------------
    logic                   s3_valid_reg;
    logic                   s3_pxd_neg_reg;
    logic [XX_W-1:0]        s3_dxx_reg, s3_pxd_reg;
    logic signed [YY_W-1:0] s3_dyy_reg, s3_pyd_reg;

    always_ff @(posedge clk)
    begin
        s3_pxd_neg_reg <= s2_px_neg_reg ^ s2_dx_neg_reg;
        s3_dxx_reg     <= XX_W'(s2_dx_reg) * XX_W'(s2_dx_reg);
        s3_pxd_reg     <= XX_W'(s2_px_reg) * XX_W'(s2_dx_reg);
        s3_dyy_reg     <= YY_W'(s2_dy_reg) * YY_W'(s2_dy_reg);
        s3_pyd_reg     <= YY_W'(s2_py_reg) * YY_W'(s2_dy_reg);
    end

    // ------------------------------------------------------------------
    // stage 4: squared length and projection
    // ------------------------------------------------------------------
    logic                    s4_valid_reg;
    logic [LEN_W-1:0]        s4_len_reg;
    logic signed [NUM_W-1:0] s4_num_reg;

    logic signed [NUM_W-1:0] pxd_s;

    always_comb
    begin
        pxd_s = $signed({3'b000, s3_pxd_reg});
    end

    always_ff @(posedge clk)
    begin
        // y square is never negative
        s4_len_reg <= LEN_W'(s3_dxx_reg) + LEN_W'(s3_dyy_reg[YY_W-2:0]);
        s4_num_reg <= (s3_pxd_neg_reg ? -pxd_s : pxd_s) + NUM_W'(s3_pyd_reg);
    end

    // ------------------------------------------------------------------
    // stage 5 and divider: range check, then one quotient bit per stage
    // index 0 holds the range check output, index W the full quotient
    // ------------------------------------------------------------------
    logic             div_valid_reg [0:W];
    logic             div_zero_reg  [0:W];
    logic             div_full_reg  [0:W];
    logic [LEN_W-1:0] div_rem_reg   [0:W];
    logic [LEN_W-1:0] div_len_reg   [0:W];
    logic [W-1:0]     div_q_reg     [0:W];

    logic [LEN_W:0]   div_shift [0:W-1];
    logic [LEN_W:0]   div_diff  [0:W-1];
    logic             div_ge    [0:W-1];

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            div_shift[i] = {div_rem_reg[i], 1'b0};
            div_diff[i]  = div_shift[i] - {1'b0, div_len_reg[i]};
            div_ge[i]    = div_shift[i] >= {1'b0, div_len_reg[i]};
        end
    end

    logic s4_le_zero;

    always_comb
    begin
        s4_le_zero = s4_num_reg[NUM_W-1] || (s4_num_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        // zero-length line or projection at or before the start point
        div_zero_reg[0] <= (s4_len_reg == '0) || s4_le_zero;
        // projection at or past the end point
        div_full_reg[0] <= !s4_le_zero && (s4_num_reg[LEN_W-1:0] >= s4_len_reg);
        div_rem_reg[0]  <= s4_num_reg[LEN_W-1:0];
        div_len_reg[0]  <= s4_len_reg;
        div_q_reg[0]    <= '0;
        for (int i = 0; i < W; i++)
        begin
            div_zero_reg[i+1] <= div_zero_reg[i];
            div_full_reg[i+1] <= div_full_reg[i];
            div_len_reg[i+1]  <= div_len_reg[i];
            div_rem_reg[i+1]  <= div_ge[i] ? div_diff[i][LEN_W-1:0] : div_shift[i][LEN_W-1:0];
            div_q_reg[i+1]    <= {div_q_reg[i][W-2:0], div_ge[i]};
        end
    end

    // ------------------------------------------------------------------
    // square stage: t2 = round(t*t), k = 3 - 2t
    // ------------------------------------------------------------------
    logic         sq_valid_reg;
    logic         sq_zero_reg, sq_full_reg;
    logic [W-1:0] sq_t2_reg;
    logic [W+1:0] sq_k_reg;

    logic [2*W-1:0] tt;

    always_comb
    begin
        tt = (2*W)'(div_q_reg[W]) * (2*W)'(div_q_reg[W]) + TT_HALF;
    end

    always_ff @(posedge clk)
    begin
        sq_zero_reg <= div_zero_reg[W];
        sq_full_reg <= div_full_reg[W];
        sq_t2_reg   <= tt[2*W-1:W];
        sq_k_reg    <= K_THREE - {1'b0, div_q_reg[W], 1'b0};
    end

    // ------------------------------------------------------------------
    // smoothstep product: s = round(t2 * k)
    // ------------------------------------------------------------------
    logic         s_valid_reg;
    logic         s_zero_reg, s_full_reg;
    logic [W+1:0] s_val_reg;

    logic [2*W+1:0] sk;

    always_comb
    begin
        sk = (2*W+2)'(sq_t2_reg) * (2*W+2)'(sq_k_reg) + P_HALF;
    end

    always_ff @(posedge clk)
    begin
        s_zero_reg <= sq_zero_reg;
        s_full_reg <= sq_full_reg;
        s_val_reg  <= sk[2*W+1:W];
    end

    // ------------------------------------------------------------------
    // output stage: special cases and saturation to all ones
    // ------------------------------------------------------------------
    logic                          done_reg;
    logic [lgmw_pkg::WEIGHT_W-1:0] weight_reg;

    logic [W-1:0]  w_sel;
    logic [WX-1:0] w_ext;

    always_comb
    begin
        if (s_zero_reg)
        begin
            w_sel = '0;
        end
        else if (s_full_reg || (s_val_reg > S_MAX))
        begin
            w_sel = '1;
        end
        else
        begin
            w_sel = s_val_reg[W-1:0];
        end
        w_ext = WX'(w_sel);
    end

    always_ff @(posedge clk)
    begin
        if (s_valid_reg)
        begin
            weight_reg <= w_ext[lgmw_pkg::WEIGHT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int i = 0; i <= W; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
            sq_valid_reg <= 1'b0;
            s_valid_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= start && !busy;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            div_valid_reg[0] <= s4_valid_reg;
            for (int i = 0; i < W; i++)
            begin
                div_valid_reg[i+1] <= div_valid_reg[i];
            end
            sq_valid_reg <= div_valid_reg[W];
            s_valid_reg  <= sq_valid_reg;
            done_reg     <= s_valid_reg;
        end
    end

    assign done   = done_reg;
    assign weight = weight_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // every accepted pixel gives exactly one weight, raised on done by the
    // output stage register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(W+8) done)
        else $error("pixel beat produced no weight beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, W+8))
        else $error("weight beat without a pixel beat");

    // zero-length line or projection before start gives weight zero
    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && s_zero_reg) |=> (done && (weight == '0)))
        else $error("zero case produced a nonzero weight");

    // past the end saturates to all ones
    a_full_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && !s_zero_reg && s_full_reg)
        |=> (done && (weight == lgmw_pkg::WEIGHT_W'({W{1'b1}}))))
        else $error("full case weight not saturated");

endmodule

/* tb/lgmw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgmw_checker
// Watches the config writes, pixel beats and weight beats of the gradient
// mask block, predicts each weight and compares it in arrival order.
// ----------------------------------------------------------------------------
module lgmw_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lgmw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgmw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            start,
    input  logic                            busy,
    input  logic [lgmw_pkg::PIXEL_W-1:0]    pixel_u,
    input  logic [lgmw_pkg::PIXEL_W-1:0]    pixel_v,
    input  logic                            done,
    input  logic [lgmw_pkg::WEIGHT_W-1:0]   weight,
    output int                              errors,
    output int                              pending
);

    localparam int WBITS = lgmw_pkg::WEIGHT_BITS_DEF;

    typedef struct {
        logic [lgmw_pkg::PIXEL_W-1:0]  u;
        logic [lgmw_pkg::PIXEL_W-1:0]  v;
        logic [lgmw_pkg::WEIGHT_W-1:0] w;
    } pixel_weight_t;

    // shadow of the gradient registers
    logic signed [lgmw_pkg::COORD_W-1:0] start_x_r;
    logic signed [lgmw_pkg::COORD_W-1:0] start_y_r;
    logic signed [lgmw_pkg::COORD_W-1:0] end_x_r;
    logic signed [lgmw_pkg::COORD_W-1:0] end_y_r;
    logic [lgmw_pkg::ASPECT_W-1:0]       aspect_r;

    pixel_weight_t weight_q[$];
    pixel_weight_t oldest;

    // x difference times aspect, rounded half away from zero
    function automatic longint aspect_scale(input longint d);
        longint mag;
        mag = (d < 0) ? -d : d;
        mag = (mag * longint'(aspect_r) + (64'sd1 <<< (lgmw_pkg::ASPECT_FRAC - 1)))
              >>> lgmw_pkg::ASPECT_FRAC;
        return (d < 0) ? -mag : mag;
    endfunction

    function automatic logic [lgmw_pkg::WEIGHT_W-1:0] gradient_weight(
        input logic [lgmw_pkg::PIXEL_W-1:0] u,
        input logic [lgmw_pkg::PIXEL_W-1:0] v
    );
        longint sx, sy, dx, dy, px, py;
        longint len2, num, rem, t, t2, k, s, one;
        int     i;
        one = 64'sd1 <<< WBITS;
        sx  = start_x_r;
        sy  = start_y_r;
        dx  = aspect_scale(longint'(end_x_r) - sx);
        dy  = longint'(end_y_r) - sy;
        px  = aspect_scale(longint'(u) - sx);
        py  = longint'(v) - sy;
        len2 = dx * dx + dy * dy;
        num  = px * dx + py * dy;
        if (len2 == 0 || num <= 0)
            return '0;
        if (num >= len2)
            return lgmw_pkg::WEIGHT_W'(one - 1);
        // restoring division, one quotient bit per pass
        rem = num;
        t   = 0;
        for (i = 0; i < WBITS; i++)
        begin
            rem = rem <<< 1;
            t   = t <<< 1;
            if (rem >= len2)
            begin
                rem = rem - len2;
                t   = t | 1;
            end
        end
        t2 = (t * t + (one >>> 1)) >>> WBITS;
        k  = 3 * one - 2 * t;
        s  = (t2 * k + (one >>> 1)) >>> WBITS;
        if (s > one - 1)
            s = one - 1;
        return lgmw_pkg::WEIGHT_W'(s);
    endfunction

    task automatic flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_r = lgmw_pkg::START_X_RST;
            start_y_r = lgmw_pkg::START_Y_RST;
            end_x_r   = lgmw_pkg::END_X_RST;
            end_y_r   = lgmw_pkg::END_Y_RST;
            aspect_r  = lgmw_pkg::ASPECT_RST;
            weight_q.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    lgmw_pkg::REG_START_X:      start_x_r = cfg_data;
                    lgmw_pkg::REG_START_Y:      start_y_r = cfg_data;
                    lgmw_pkg::REG_END_X:        end_x_r   = cfg_data;
                    lgmw_pkg::REG_END_Y:        end_y_r   = cfg_data;
                    lgmw_pkg::REG_ASPECT_RATIO:
                        aspect_r = cfg_data[lgmw_pkg::ASPECT_W-1:0];
                    default:                    ;
                endcase
            end
            // retire before taking the new beat
            if (done)
            begin
                if (weight_q.size() == 0)
                    flag($sformatf("unexpected weight beat %0d", weight));
                else
                begin
                    oldest = weight_q.pop_front();
                    if (weight !== oldest.w)
                        flag($sformatf("pixel (%0d,%0d): expected weight %0d, got %0d",
                                       oldest.u, oldest.v, oldest.w, weight));
                end
            end
            if (start && !busy)
                weight_q.push_back('{pixel_u, pixel_v, gradient_weight(pixel_u, pixel_v)});
            pending = weight_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives config writes and pixel beats into the linear gradient mask weight
// block and reports the verdict of the checker that runs beside it.
// ----------------------------------------------------------------------------
module tb_top;

    // weight beat follows the pixel beat by this many clocks
    localparam int LATENCY      = lgmw_pkg::WEIGHT_BITS_DEF + 7;
    // random pixel beats, spread over many gradient settings
    localparam int RANDOM_ITEMS = 1700;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [lgmw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lgmw_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            start;
    logic                            busy;
    logic [lgmw_pkg::PIXEL_W-1:0]    pixel_u;
    logic [lgmw_pkg::PIXEL_W-1:0]    pixel_v;
    logic                            done;
    logic [lgmw_pkg::WEIGHT_W-1:0]   weight;

    int errors;
    int pending;
    int sent;
    // a bursty phase sends back-to-back beats
    bit bursty;

    always #5 clk = ~clk;

    linear_gradient_mask_weight dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .pixel_u   (pixel_u),
        .pixel_v   (pixel_v),
        .done      (done),
        .weight    (weight)
    );

    lgmw_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .pixel_u   (pixel_u),
        .pixel_v   (pixel_v),
        .done      (done),
        .weight    (weight),
        .errors    (errors),
        .pending   (pending)
    );

    // idle length before a pixel beat: mostly none, a few long ones
    function automatic int pick_gap();
        int r;
        if (bursty)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // gradient point: mostly near the image, sometimes anywhere or at the rails
    function automatic logic [lgmw_pkg::COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return lgmw_pkg::COORD_W'(int'($urandom_range(0, 98304)) - 16384);
        if (r < 90)
            return lgmw_pkg::COORD_W'($urandom);
        case ($urandom_range(0, 2))
            0:       return 18'h20000;
            1:       return 18'h1FFFF;
            default: return '0;
        endcase
    endfunction

    // aspect with junk in the bits above the register width
    function automatic logic [lgmw_pkg::CFG_DATA_W-1:0] rand_aspect();
        int                            r;
        logic [lgmw_pkg::ASPECT_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 6)
            a = lgmw_pkg::ASPECT_W'($urandom_range(0, 1023));   // below range, zero included
        else if (r < 12)
            a = ($urandom_range(0, 1) != 0) ? 16'd1024 : 16'hFFFF;
        else
            a = lgmw_pkg::ASPECT_W'($urandom_range(1024, 65535));
        return {2'($urandom), a};
    endfunction

    function automatic logic [lgmw_pkg::PIXEL_W-1:0] rand_pixel();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return lgmw_pkg::PIXEL_W'($urandom);
    endfunction

    // every driver task starts and ends just after a rising edge
    task automatic write_reg(input logic [lgmw_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [lgmw_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_gradient(input logic [lgmw_pkg::COORD_W-1:0]    sx,
                                input logic [lgmw_pkg::COORD_W-1:0]    sy,
                                input logic [lgmw_pkg::COORD_W-1:0]    ex,
                                input logic [lgmw_pkg::COORD_W-1:0]    ey,
                                input logic [lgmw_pkg::CFG_DATA_W-1:0] asp);
        write_reg(lgmw_pkg::REG_START_X, sx);
        write_reg(lgmw_pkg::REG_START_Y, sy);
        write_reg(lgmw_pkg::REG_END_X, ex);
        write_reg(lgmw_pkg::REG_END_Y, ey);
        write_reg(lgmw_pkg::REG_ASPECT_RATIO, asp);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // indexes past the register list must be dropped by the block
    task automatic write_unused_regs();
        int k;
        for (k = int'(lgmw_pkg::REG_ASPECT_RATIO) + 1; k < (1 << lgmw_pkg::CFG_IDX_W); k++)
            write_reg(lgmw_pkg::CFG_IDX_W'(k), lgmw_pkg::CFG_DATA_W'($urandom));
    endtask

    // one pixel beat, accepted at an edge with start high and busy low
    task automatic send_pixel(input logic [lgmw_pkg::PIXEL_W-1:0] u,
                              input logic [lgmw_pkg::PIXEL_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        pixel_u <= u;
        pixel_v <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and wait for every predicted weight to come back;
    // the checker is read on the falling edge so its update has settled
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int n;
        logic [lgmw_pkg::COORD_W-1:0] sx, sy, ex, ey;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        start     <= 1'b0;
        pixel_u   <= '0;
        pixel_v   <= '0;
        bursty     = 1'b0;
        sent       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset gradient: vertical line from (0,0) to (0,1.0), corners and middle
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(16'h8000, 16'h8000);
        send_pixel('0, '1);
        send_pixel('1, '0);
        send_pixel(16'd12345, 16'hC000);
        drain();

        // zero-length line, start on end
        set_gradient('0, '0, '0, '0, lgmw_pkg::ASPECT_RST);
        send_pixel(16'h4000, 16'h4000);
        send_pixel('1, '1);
        drain();

        // line of one lsb that the aspect scaling rounds away to nothing;
        // writes to unused indexes go in just before it
        write_unused_regs();
        set_gradient('0, '0, 18'd1, '0, 18'd1024);
        send_pixel('1, '0);
        send_pixel(16'h0001, 16'h8000);
        drain();

        // aspect of zero collapses x, only y is left
        set_gradient('0, '0, 18'h10000, 18'h08000, '0);
        send_pixel('1, 16'h4000);
        send_pixel('0, '1);
        drain();

        // both points at opposite rails, widest aspect
        set_gradient(18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h0FFFF);
        send_pixel('0, '0);
        send_pixel('1, '1);
        drain();

        // same line pointing the other way, narrowest in-range aspect
        set_gradient(18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000, 18'd1024);
        send_pixel('0, '0);
        send_pixel('1, '1);
        drain();

        // horizontal unit line: t just below one rounds up and saturates,
        // t of one half lands exactly on the curve midpoint
        set_gradient('0, '0, 18'h10000, '0, lgmw_pkg::ASPECT_RST);
        send_pixel('1, 16'h1234);
        send_pixel(16'h8000, '0);
        send_pixel(16'hFFFE, '1);
        drain();

        // random phases: new gradient, a run of pixels, then drain
        while (sent < RANDOM_ITEMS)
        begin
            bursty = ($urandom_range(0, 3) == 0);
            sx = rand_coord();
            sy = rand_coord();
            ex = rand_coord();
            ey = rand_coord();
            if ($urandom_range(0, 19) == 0)
            begin
                ex = sx;
                ey = sy;
            end
            if ($urandom_range(0, 9) == 0)
                write_unused_regs();
            set_gradient(sx, sy, ex, ey, rand_aspect());
            n = $urandom_range(20, 120);
            repeat (n)
            begin
                send_pixel(rand_pixel(), rand_pixel());
                sent++;
            end
            drain();
        end

        // let any stray weight beat show up before the verdict
        repeat (LATENCY + 8) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("linear_gradient_mask_weight: match");
        else
            $display("linear_gradient_mask_weight: mismatch");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("linear_gradient_mask_weight: mismatch");
        $finish;
    end

endmodule
